// ===== hw/rtl/bbr_pkg.sv =====
// shared types, widths and divider constants for the 3x3 box blur
package bbr_pkg;

	localparam int CH_W        = 8;
	localparam int WIN_N       = 9;
	localparam int CNT_W       = 4;
	localparam int SUM_W       = 12;
	localparam int NUM_W       = 13;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int OUT_ROW_W   = 12;
	localparam int OUT_COL_W   = 10;
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} tag_t;

	// ceil(2^20 / (2*count)); exact for every numerator 2*sum+count that can occur
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		unique case (count)
			4'd2:    m = 20'd262144;
			4'd3:    m = 20'd174763;
			4'd4:    m = 20'd131072;
			4'd5:    m = 20'd104858;
			4'd6:    m = 20'd87382;
			4'd7:    m = 20'd74899;
			4'd8:    m = 20'd65536;
			4'd9:    m = 20'd58255;
			default: m = 20'd524288;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/bbr_ram.sv =====
// generic single write port ram with registered read
module bbr_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bbr_lane.sv =====
// one colour channel: masked window sum, rounded mean by reciprocal multiply
module bbr_lane import bbr_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic [WIN_N-1:0][CH_W-1:0]  pix,
	input  logic [WIN_N-1:0]            mask,
	input  logic [CNT_W-1:0]            count,
	output logic [CH_W-1:0]             q
);

	logic [SUM_W-1:0]   sum;
	logic [NUM_W-1:0]   num_s1;
	logic [RECIP_W-1:0] recip_s1;
	logic [PROD_W-1:0]  prod;
	logic [CH_W-1:0]    q_s2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (mask[i]) begin
				sum = sum + SUM_W'(pix[i]);
			end
		end
	end

	// numerator 2*sum+count, divided by 2*count in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1   <= {sum, 1'b0} + NUM_W'(count);
			recip_s1 <= recip_of(count);
		end
	end

	assign prod = PROD_W'(num_s1) * PROD_W'(recip_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= prod[RECIP_SHIFT +: CH_W];
		end
	end

	assign q = q_s2;

endmodule

// ===== hw/rtl/bbr_out.sv =====
// merges the three lane results with the position tag into the output register
module bbr_out import bbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  tag_t                  res_tag,
	input  logic [CH_W-1:0]       res_red,
	input  logic [CH_W-1:0]       res_green,
	input  logic [CH_W-1:0]       res_blue,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [CH_W-1:0]       blur_red,
	output logic [CH_W-1:0]       blur_green,
	output logic [CH_W-1:0]       blur_blue,
	output logic [OUT_ROW_W-1:0]  out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  run_last,
	output logic                  advance
);

	logic   out_valid_q;
	pixel_t pix_q;
	tag_t   tag_q;

	// whole pipeline moves when the output register is free or being taken
	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q <= '{red: res_red, green: res_green, blue: res_blue};
			tag_q <= res_tag;
		end
	end

	assign out_valid  = out_valid_q;
	assign blur_red   = pix_q.red;
	assign blur_green = pix_q.green;
	assign blur_blue  = pix_q.blue;
	assign out_row    = tag_q.row;
	assign out_col    = tag_q.col;
	assign run_last   = tag_q.last;

endmodule

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// top level of the 3x3 box blur: counters, line stores, window, result issue
//
//  channel  handshake              payload
//  in       in_valid / in_ready    pixel_red, pixel_green, pixel_blue
//  out      out_valid / out_ready  blur_red/green/blue, out_row, out_col, run_last
//  cfg      cfg_we                 cfg_index, cfg_data
//
// a pixel giving n results (0 to 4) has them issued one at a time;
// with one result per pixel the block takes a pixel every cycle while out does not stall.
// an issued result passes the lane stages s1 and s2 into the output register; the three
// channel lanes share one issue slot, which sets the rate at row ends and on the last row.
// a stall on out stops the whole result pipeline and holds in_ready low while results are pending.
// no clearing pass after reset: line store contents outside the frame are masked off.
module box_blur_3x3_rgb import bbr_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CH_W-1:0]       pixel_red,
	input  logic [CH_W-1:0]       pixel_green,
	input  logic [CH_W-1:0]       pixel_blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       blur_red,
	output logic [CH_W-1:0]       blur_green,
	output logic [CH_W-1:0]       blur_blue,
	output logic [OUT_ROW_W-1:0]  out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  run_last
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WBITS = $clog2(MAX_WIDTH + 1);
	localparam int HBITS = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP  = (WBITS > IMG_W_BITS) ? WBITS : IMG_W_BITS;
	localparam int HCMP  = (HBITS > IMG_H_BITS) ? HBITS : IMG_H_BITS;
	localparam int LS_W  = 2 * $bits(pixel_t);

	// result kinds, in issue order
	localparam int EMIT_PREV_DIAG = 0;
	localparam int EMIT_PREV_END  = 1;
	localparam int EMIT_CUR_DIAG  = 2;
	localparam int EMIT_CUR_END   = 3;

	logic [IMG_W_BITS-1:0] cfg_width_q;
	logic [IMG_H_BITS-1:0] cfg_height_q;
	logic [WCMP-1:0]       w_eff;
	logic [HCMP-1:0]       h_eff;

	logic [COL_W-1:0] col_q, col_next, raddr;
	logic [ROW_W-1:0] row_q, row_next;
	logic             last_col, last_row, accept;

	pixel_t           in_pix;
	logic [LS_W-1:0]  ls_rdata, ls_wdata, byp_data_q;
	logic             byp_q;
	pixel_t           upper_rd, lower_rd;

	pixel_t           win_q [WIN_N];
	logic [ROW_W-1:0] item_row_q;
	logic [COL_W-1:0] item_col_q;
	logic [2:0]       rowv_q, colv_q;
	logic [3:0]       pend_q, pend_new, sel;
	logic             issue, issue_last, advance;
	logic [2:0]       rowsel, colsel;
	logic [WIN_N-1:0] mask;
	logic [CNT_W-1:0] count;
	logic [ROW_W-1:0] emit_row;
	logic [COL_W-1:0] emit_col;
	tag_t             issue_tag, tag_s1, tag_s2;
	logic             valid_s1, valid_s2;

	logic [WIN_N-1:0][CH_W-1:0] lane_pix [3];
	logic [CH_W-1:0]            lane_q   [3];

	// configuration and effective frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= IMG_W_BITS'(1024);
			cfg_height_q <= IMG_H_BITS'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data[IMG_H_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = WCMP'(1);
		end else if (WCMP'(cfg_width_q) > WCMP'(MAX_WIDTH)) begin
			w_eff = WCMP'(MAX_WIDTH);
		end else begin
			w_eff = WCMP'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = HCMP'(1);
		end else if (HCMP'(cfg_height_q) > HCMP'(MAX_HEIGHT)) begin
			h_eff = HCMP'(MAX_HEIGHT);
		end else begin
			h_eff = HCMP'(cfg_height_q);
		end
	end

	// position of the next pixel
	assign last_col = (WCMP'(col_q) == w_eff - WCMP'(1));
	assign last_row = (HCMP'(row_q) == h_eff - HCMP'(1));
	assign col_next = last_col ? '0 : col_q + COL_W'(1);
	assign row_next = last_col ? (last_row ? '0 : row_q + ROW_W'(1)) : row_q;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// line stores: one ram holding the two previous rows side by side;
	// the read runs one column ahead so the data is waiting when a pixel arrives
	assign in_pix   = '{red: pixel_red, green: pixel_green, blue: pixel_blue};
	assign raddr    = cfg_we ? '0 : (accept ? col_next : col_q);
	assign ls_wdata = {lower_rd, in_pix};

	bbr_ram #(
		.WIDTH (LS_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (ls_wdata),
		.raddr (raddr),
		.rdata (ls_rdata)
	);

	// a one-pixel-wide frame reads the column it just wrote
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= accept && (raddr == col_q);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ls_wdata;
	end

	assign {upper_rd, lower_rd} = byp_q ? byp_data_q : ls_rdata;

	// 3x3 window, row-major, oldest column first
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				win_q[3*k]   <= win_q[3*k+1];
				win_q[3*k+1] <= win_q[3*k+2];
			end
			win_q[2] <= upper_rd;
			win_q[5] <= lower_rd;
			win_q[8] <= in_pix;
		end
	end

	// results owed by the accepted pixel
	always_comb begin
		pend_new                 = '0;
		pend_new[EMIT_PREV_DIAG] = (row_q != '0) && (col_q != '0);
		pend_new[EMIT_PREV_END]  = (row_q != '0) && last_col;
		pend_new[EMIT_CUR_DIAG]  = last_row && (col_q != '0);
		pend_new[EMIT_CUR_END]   = last_row && last_col;
	end

	assign sel        = pend_q & (~pend_q + 4'd1);
	assign issue_last = ((pend_q & ~sel) == '0);
	assign issue      = advance && (pend_q != '0);
	assign in_ready   = (pend_q == '0) || (advance && issue_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (accept) begin
			pend_q <= pend_new;
		end else if (issue) begin
			pend_q <= pend_q & ~sel;
		end
	end

	// window rows/columns that lie inside the frame
	always_ff @(posedge clk) begin
		if (accept) begin
			item_row_q <= row_q;
			item_col_q <= col_q;
			rowv_q     <= {1'b1, row_q != '0, row_q > ROW_W'(1)};
			colv_q     <= {1'b1, col_q != '0, col_q > COL_W'(1)};
		end
	end

	// neighbourhood of the result being issued
	always_comb begin
		rowsel = rowv_q;
		colsel = colv_q;
		if (sel[EMIT_CUR_DIAG] || sel[EMIT_CUR_END]) begin
			rowsel[0] = 1'b0;
		end
		if (sel[EMIT_PREV_END] || sel[EMIT_CUR_END]) begin
			colsel[0] = 1'b0;
		end
		count = '0;
		for (int k = 0; k < 3; k++) begin
			for (int m = 0; m < 3; m++) begin
				mask[3*k+m] = rowsel[k] && colsel[m];
			end
		end
		for (int i = 0; i < WIN_N; i++) begin
			count = count + CNT_W'(mask[i]);
		end
		emit_row = (sel[EMIT_PREV_DIAG] || sel[EMIT_PREV_END]) ?
			item_row_q - ROW_W'(1) : item_row_q;
		emit_col = (sel[EMIT_PREV_DIAG] || sel[EMIT_CUR_DIAG]) ?
			item_col_q - COL_W'(1) : item_col_q;
		issue_tag.row  = OUT_ROW_W'(emit_row);
		issue_tag.col  = OUT_COL_W'(emit_col);
		issue_tag.last = issue_last;
	end

	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			lane_pix[0][i] = win_q[i].red;
			lane_pix[1][i] = win_q[i].green;
			lane_pix[2][i] = win_q[i].blue;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		bbr_lane u_lane (
			.clk   (clk),
			.en    (advance),
			.pix   (lane_pix[ch]),
			.mask  (mask),
			.count (count),
			.q     (lane_q[ch])
		);
	end

	// valid and tag travel alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tag_s1 <= issue_tag;
			tag_s2 <= tag_s1;
		end
	end

	bbr_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (valid_s2),
		.res_tag    (tag_s2),
		.res_red    (lane_q[0]),
		.res_green  (lane_q[1]),
		.res_blue   (lane_q[2]),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.blur_red   (blur_red),
		.blur_green (blur_green),
		.blur_blue  (blur_blue),
		.out_row    (out_row),
		.out_col    (out_col),
		.run_last   (run_last),
		.advance    (advance)
	);

endmodule

// ===== tb/sv/box_blur_3x3_rgb_tb.sv =====
// self-checking testbench for the 3x3 rgb box blur with its own blur predictor
`timescale 1ns / 1ps
module box_blur_3x3_rgb_tb;
	import bbr_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 4096;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int PIXEL_TARGET  = 270;
	localparam int QUIET_PIXELS  = 48;
	localparam int PRINT_LIMIT   = 40;

	typedef struct {
		logic [CH_W-1:0]      red;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      blue;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} blur_result_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [CH_W-1:0]       pixel_red   = '0;
	logic [CH_W-1:0]       pixel_green = '0;
	logic [CH_W-1:0]       pixel_blue  = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [CH_W-1:0]       blur_red;
	logic [CH_W-1:0]       blur_green;
	logic [CH_W-1:0]       blur_blue;
	logic [OUT_ROW_W-1:0]  out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  run_last;

	// predictor state: line stores, window, position and size registers
	pixel_t line_upper [MAX_W];
	pixel_t line_lower [MAX_W];
	pixel_t win [WIN_N];
	int     width_reg  = 1024;
	int     height_reg = 1024;
	int     next_row   = 0;
	int     next_col   = 0;

	pixel_t       pixels_to_send [$];
	blur_result_t expected_blurs [$];

	int error_count     = 0;
	int pixels_queued   = 0;
	int pixels_accepted = 0;
	int blurs_checked   = 0;
	int writes_done     = 0;
	int idle_cycles     = 0;
	bit no_idle         = 1'b0;
	bit hold_request    = 1'b0;

	box_blur_3x3_rgb #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blur_red   (blur_red),
		.blur_green (blur_green),
		.blur_blue  (blur_blue),
		.out_row    (out_row),
		.out_col    (out_col),
		.run_last   (run_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int effective_size(input int value, input int top);
		if (value < 1)
			return 1;
		if (value > top)
			return top;
		return value;
	endfunction

	// rounded mean of the in-frame neighbours of (cr, cc); window holds rows r-2..r, cols c-2..c
	function automatic blur_result_t blur_at(input int cr, input int cc, input int r, input int c,
			input int w, input int h);
		int sum_r, sum_g, sum_b, cnt, di, dj, ni, nj, wk, wm;
		blur_result_t res;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		cnt = 0;
		for (di = -1; di <= 1; di++) begin
			for (dj = -1; dj <= 1; dj++) begin
				ni = cr + di;
				nj = cc + dj;
				wk = ni - (r - 2);
				wm = nj - (c - 2);
				if (ni >= 0 && ni < h && nj >= 0 && nj < w && wk >= 0 && wk <= 2 &&
						wm >= 0 && wm <= 2) begin
					sum_r += int'(win[wk * 3 + wm].red);
					sum_g += int'(win[wk * 3 + wm].green);
					sum_b += int'(win[wk * 3 + wm].blue);
					cnt++;
				end
			end
		end
		if (cnt == 0)
			cnt = 1;
		res.red = CH_W'((2 * sum_r + cnt) / (2 * cnt));
		res.green = CH_W'((2 * sum_g + cnt) / (2 * cnt));
		res.blue = CH_W'((2 * sum_b + cnt) / (2 * cnt));
		res.row = OUT_ROW_W'(cr);
		res.col = OUT_COL_W'(cc);
		res.last = 1'b0;
		return res;
	endfunction

	task automatic blur_step(input pixel_t px);
		int w, h, r, c, k;
		bit bottom_row, right_col;
		blur_result_t found [$];
		w = effective_size(width_reg, MAX_W);
		h = effective_size(height_reg, MAX_H);
		r = next_row;
		c = next_col;
		if (r >= h)
			r = 0;
		if (c >= w)
			c = 0;
		bottom_row = (r == h - 1);
		right_col = (c == w - 1);
		for (k = 0; k < 3; k++) begin
			win[k * 3] = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = line_upper[c];
		win[5] = line_lower[c];
		win[8] = px;
		line_upper[c] = line_lower[c];
		line_lower[c] = px;
		// one row and one column behind; the right column and the bottom row get flushed
		if (r >= 1 && c >= 1)
			found.push_back(blur_at(r - 1, c - 1, r, c, w, h));
		if (r >= 1 && right_col)
			found.push_back(blur_at(r - 1, w - 1, r, c, w, h));
		if (bottom_row && c >= 1)
			found.push_back(blur_at(r, c - 1, r, c, w, h));
		if (bottom_row && right_col)
			found.push_back(blur_at(r, w - 1, r, c, w, h));
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			expected_blurs.push_back(found[i]);
		if (right_col) begin
			next_col = 0;
			next_row = bottom_row ? 0 : r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
	endtask

	task automatic report_mismatch(input string what, input int row, input int col, input int got,
			input int want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t: %s at row %0d col %0d: got %0d, want %0d", $time, what, row, col, got,
				want);
	endtask

	// register write; any write restarts the frame, stored pixels stay
	task automatic write_reg(input reg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		if (idx == REG_IMAGE_WIDTH)
			width_reg = int'(value[IMG_W_BITS-1:0]);
		else
			height_reg = int'(value[IMG_H_BITS-1:0]);
		next_row = 0;
		next_col = 0;
		writes_done++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_pixel(input pixel_t px);
		pixels_to_send.push_back(px);
		pixels_queued++;
	endtask

	function automatic logic [CH_W-1:0] channel_value();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return CH_W'($urandom_range(0, 255));
	endfunction

	task automatic queue_random(input int n);
		int k;
		for (k = 0; k < n; k++)
			queue_pixel({channel_value(), channel_value(), channel_value()});
	endtask

	task automatic wait_for_results();
		while (pixels_to_send.size() > 0 || in_valid || expected_blurs.size() > 0)
			@(posedge clk);
	endtask

	// pixels that give no result may still be in flight; let them settle before a write
	task automatic drain_block();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pixel sender
	always @(posedge clk) begin : drive_pixels
		int send_gap;
		pixel_t px;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				blur_step({pixel_red, pixel_green, pixel_blue});
				pixels_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!no_idle && pixels_to_send.size() > 0 &&
						$urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 18);
					in_valid <= 1'b0;
				end else if (pixels_to_send.size() > 0) begin
					px = pixels_to_send.pop_front();
					pixel_red <= px.red;
					pixel_green <= px.green;
					pixel_blue <= px.blue;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk) begin : take_blurs
		int recv_gap;
		int hold_left;
		bit hold_taken;
		blur_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				blurs_checked++;
				if (expected_blurs.size() == 0) begin
					report_mismatch("unexpected result", int'(out_row), int'(out_col),
						int'({blur_red, blur_green, blur_blue}), 0);
				end else begin
					want = expected_blurs.pop_front();
					if (blur_red !== want.red)
						report_mismatch("blur_red", int'(want.row), int'(want.col),
							int'(blur_red), int'(want.red));
					if (blur_green !== want.green)
						report_mismatch("blur_green", int'(want.row), int'(want.col),
							int'(blur_green), int'(want.green));
					if (blur_blue !== want.blue)
						report_mismatch("blur_blue", int'(want.row), int'(want.col),
							int'(blur_blue), int'(want.blue));
					if (out_row !== want.row)
						report_mismatch("out_row", int'(want.row), int'(want.col),
							int'(out_row), int'(want.row));
					if (out_col !== want.col)
						report_mismatch("out_col", int'(want.row), int'(want.col),
							int'(out_col), int'(want.col));
					if (run_last !== want.last)
						report_mismatch("run_last", int'(want.row), int'(want.col),
							int'(run_last), int'(want.last));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request && !hold_taken) begin
				// long back-pressure so the block fills and stalls its input
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				recv_gap = $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("no transaction for %0d cycles, %0d results outstanding", IDLE_LIMIT,
			expected_blurs.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int w, h, k;
		foreach (line_upper[i]) begin
			line_upper[i] = '0;
			line_lower[i] = '0;
		end
		foreach (win[i])
			win[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-pixel frames: each mean is of a single pixel
		write_reg(REG_IMAGE_WIDTH, 1);
		write_reg(REG_IMAGE_HEIGHT, 1);
		queue_pixel({8'h00, 8'h00, 8'h00});
		queue_pixel({8'hFF, 8'hFF, 8'hFF});
		drain_block();

		// 3x3 frame: corner, edge and centre neighbourhoods of 4, 6 and 9
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		for (k = 0; k < 9; k++)
			queue_pixel({(k % 2) ? 8'hFF : 8'h00, (k == 4) ? 8'hFF : 8'h00,
				(k < 3) ? 8'hFF : 8'h01});
		drain_block();

		// zero width acts as one: a single column with 2 and 3 neighbours
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 3);
		queue_pixel({8'hFF, 8'h00, 8'h80});
		queue_pixel({8'h00, 8'hFF, 8'h7F});
		queue_pixel({8'hFF, 8'hFF, 8'h01});
		drain_block();

		// oversized width clamps to the maximum, zero height to one row; frame cut short
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 0);
		queue_pixel({8'hFF, 8'hFF, 8'hFF});
		queue_pixel({8'h00, 8'h00, 8'h00});
		queue_pixel({8'hFF, 8'h00, 8'hFF});
		queue_pixel({8'h01, 8'hFE, 8'h00});
		drain_block();

		// tallest frame, restarted after a few pixels
		write_reg(REG_IMAGE_WIDTH, 2);
		write_reg(REG_IMAGE_HEIGHT, 8191);
		queue_random(4);
		drain_block();

		// width bits above the register are dropped, leaving zero, which acts as one
		write_reg(REG_IMAGE_WIDTH, 13'h1000);
		write_reg(REG_IMAGE_HEIGHT, 2);
		queue_pixel({8'h00, 8'hFF, 8'h00});
		queue_pixel({8'hFF, 8'h00, 8'hFF});
		drain_block();

		// output held off for a long stretch while pixels keep coming
		write_reg(REG_IMAGE_WIDTH, 8);
		write_reg(REG_IMAGE_HEIGHT, 6);
		hold_request = 1'b1;
		queue_random(48);
		drain_block();

		// sender pauses mid-frame until every result is out
		write_reg(REG_IMAGE_WIDTH, 7);
		write_reg(REG_IMAGE_HEIGHT, 5);
		queue_random(17);
		wait_for_results();
		queue_random(18);
		drain_block();

		while (pixels_queued < PIXEL_TARGET - QUIET_PIXELS) begin
			k = $urandom_range(0, 4);
			if (k == 0) begin
				// arbitrary register values, frame cut short by the next write
				write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 8191));
				write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 8191));
				queue_random($urandom_range(8, 24));
			end else begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 6);
				if (k == 1 && effective_size(width_reg, MAX_W) <= 10)
					w = effective_size(width_reg, MAX_W);
				else
					write_reg(REG_IMAGE_WIDTH, w);
				write_reg(REG_IMAGE_HEIGHT, h);
				queue_random($urandom_range(1, 2) * w * h);
			end
			drain_block();
		end

		// closing frame at full rate, no idling on either side
		no_idle = 1'b1;
		write_reg(REG_IMAGE_WIDTH, 16);
		write_reg(REG_IMAGE_HEIGHT, 3);
		queue_random(QUIET_PIXELS);
		drain_block();

		$display("%0d pixels over %0d register writes, %0d blurred results checked",
			pixels_accepted, writes_done, blurs_checked);
		$display("frames from 1x1 up to clamped 1024x4096, masked sizes, mid-frame restarts, "
			, "long output stall and sender pause");
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
